// File: hw/rtl/bfpa_pkg.sv
// Shared types, codes and request decode for the best-fit partition allocator.
`timescale 1ns / 1ps
package bfpa_pkg;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_NO_MATCH  = 2'd3
  } status_t;

  localparam logic [1:0] CLS_BIG   = 2'd0;
  localparam logic [1:0] CLS_MID   = 2'd1;
  localparam logic [1:0] CLS_SMALL = 2'd2;
  localparam logic [1:0] CLS_NONE  = 2'd3;

  localparam logic [2:0] PRIO_MID = 3'd3;

  localparam logic [4:0] FREED_MAX = 5'd31;
  localparam logic [5:0] UNITS_MAX = 6'd63;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } cmd_t;

  function automatic logic [1:0] prio_class(input logic [2:0] prio);
    logic [1:0] c;
    if (prio < PRIO_MID) begin
      c = CLS_BIG;
    end else if (prio == PRIO_MID) begin
      c = CLS_MID;
    end else begin
      c = CLS_SMALL;
    end
    return c;
  endfunction

  function automatic logic [1:0] class_size(input logic [1:0] c);
    logic [1:0] s;
    case (c)
      CLS_BIG:   s = 2'd3;
      CLS_MID:   s = 2'd2;
      CLS_SMALL: s = 2'd1;
      default:   s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/bfpa_in_if.sv
// Request channel: valid/ready handshake with the request item.
`timescale 1ns / 1ps
interface bfpa_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] owner_id;
  logic [2:0]  priority_req;

  modport source(output valid, output kind, output owner_id, output priority_req,
                 input ready);
  modport sink(input valid, input kind, input owner_id, input priority_req,
               output ready);
endinterface

// File: hw/rtl/bfpa_out_if.sv
// Result channel: valid/ready handshake with the result item.
`timescale 1ns / 1ps
interface bfpa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] slot_index;
  logic [4:0] freed_count;
  logic [5:0] avail_units;
  logic [1:0] largest_free;

  modport source(output valid, output status, output slot_index, output freed_count,
                 output avail_units, output largest_free, input ready);
  modport sink(input valid, input status, input slot_index, input freed_count,
               input avail_units, input largest_free, output ready);
endinterface

// File: hw/rtl/bfpa_ctrl.sv
// Sequencer: accepts an item, sweeps the partition table, then commits the result.
`timescale 1ns / 1ps
module bfpa_ctrl import bfpa_pkg::*; #(
  parameter int TOTAL_SLOTS = 16,
  localparam int IW = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_busy,
  output cmd_t          cmd,
  output logic [IW-1:0] rd_idx
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT} state_t;

  localparam logic [IW-1:0] LAST_IDX = IW'(TOTAL_SLOTS - 1);

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_idx = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef SYNTH
  a_load_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cmd.rd_en && rd_idx == '0))
    else $error("sweep did not start at slot 0 after accept");

  a_commit_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!cmd.rd_en && !cmd.load))
    else $error("commit overlaps sweep or accept");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && rd_idx == LAST_IDX) |=> !cmd.rd_en)
    else $error("sweep ran past the last slot");
`endif

endmodule

// File: hw/rtl/bfpa_dp.sv
// Datapath: partition table, owner memory, best-fit search, free-space counts, result register.
`timescale 1ns / 1ps
module bfpa_dp import bfpa_pkg::*; #(
  parameter int CLASS0_SLOTS = 4,
  parameter int CLASS1_SLOTS = 4,
  parameter int CLASS2_SLOTS = 8,
  parameter int TOTAL_SLOTS  = 16,
  localparam int IW = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1,
  localparam int CW = $clog2(TOTAL_SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  input  logic [IW-1:0] rd_idx,
  input  logic          in_kind,
  input  logic [15:0]   in_owner_id,
  input  logic [2:0]    in_priority_req,
  output logic          out_busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [3:0]    out_slot_index,
  output logic [4:0]    out_freed_count,
  output logic [5:0]    out_avail_units,
  output logic [1:0]    out_largest_free
);

  localparam int B0 = CLASS0_SLOTS;
  localparam int B1 = CLASS0_SLOTS + CLASS1_SLOTS;
  localparam int B2 = CLASS0_SLOTS + CLASS1_SLOTS + CLASS2_SLOTS;

  function automatic logic [1:0] slot_class(input logic [IW-1:0] i);
    int unsigned ii;
    logic [1:0]  c;
    ii = 32'(i);
    if (ii < B0) begin
      c = CLS_BIG;
    end else if (ii < B1) begin
      c = CLS_MID;
    end else if (ii < B2) begin
      c = CLS_SMALL;
    end else begin
      c = CLS_NONE;
    end
    return c;
  endfunction

  logic [15:0]            owner_mem [TOTAL_SLOTS];
  logic [15:0]            owner_q_r;
  logic [TOTAL_SLOTS-1:0] free_r;

  logic          kind_r;
  logic [15:0]   owner_r;
  logic [1:0]    cls_r;
  logic [1:0]    dem_r;
  logic          eval_r;
  logic [IW-1:0] p_r;
  logic          found_r;
  logic [IW-1:0] best_r;
  logic [1:0]    bestw_r;
  logic [CW-1:0] freed_r;
  logic [CW-1:0] c1_r, c2_r, c3_r;

  logic          out_valid_r;
  logic [1:0]    status_r;
  logic [3:0]    slot_index_r;
  logic [4:0]    freed_count_r;
  logic [5:0]    avail_units_r;
  logic [1:0]    largest_free_r;

  logic          fj, rel_hit, post_free, cand, better, take;
  logic [1:0]    cl, sz, waste, best_sz;
  logic [CW-1:0] c1a, c2a, c3a;
  logic [8:0]    units_w, freed_w;
  logic [1:0]    largest_w;
  status_t       status_w;

  always_comb begin
    fj        = free_r[p_r];
    cl        = slot_class(p_r);
    sz        = class_size(cl);
    rel_hit   = (kind_r == KIND_RELEASE) && !fj && (owner_q_r == owner_r);
    post_free = fj || rel_hit;
    cand      = (kind_r == KIND_ALLOC) && fj && (cl == cls_r) && (sz >= dem_r);
    waste     = sz - dem_r;
    better    = cand && (!found_r || (waste < bestw_r));
  end

  always_comb begin
    take    = (kind_r == KIND_ALLOC) && found_r;
    best_sz = class_size(slot_class(best_r));
    c1a     = c1_r;
    c2a     = c2_r;
    c3a     = c3_r;
    if (take) begin
      case (best_sz)
        2'd1:    c1a = c1_r - 1'b1;
        2'd2:    c2a = c2_r - 1'b1;
        2'd3:    c3a = c3_r - 1'b1;
        default: c1a = c1_r;
      endcase
    end
    units_w = 9'(c3a) + 9'(c3a) + 9'(c3a) + 9'(c2a) + 9'(c2a) + 9'(c1a);
    if (c3a != '0) begin
      largest_w = 2'd3;
    end else if (c2a != '0) begin
      largest_w = 2'd2;
    end else if (c1a != '0) begin
      largest_w = 2'd1;
    end else begin
      largest_w = 2'd0;
    end
    freed_w = 9'(freed_r);
    if (kind_r == KIND_ALLOC) begin
      status_w = found_r ? ST_ALLOCATED : ST_NO_FIT;
    end else begin
      status_w = (freed_r != '0) ? ST_RELEASED : ST_NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && take) begin
      owner_mem[best_r] <= owner_r;
    end
    if (cmd.rd_en) begin
      owner_q_r <= owner_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      owner_r <= in_owner_id;
      cls_r   <= prio_class(in_priority_req);
      dem_r   <= class_size(prio_class(in_priority_req));
      found_r <= 1'b0;
      best_r  <= '0;
      bestw_r <= '0;
      freed_r <= '0;
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
    end else if (eval_r) begin
      if (better) begin
        found_r <= 1'b1;
        best_r  <= p_r;
        bestw_r <= waste;
      end
      if (rel_hit) begin
        freed_r <= freed_r + 1'b1;
      end
      if (post_free) begin
        case (sz)
          2'd1:    c1_r <= c1_r + 1'b1;
          2'd2:    c2_r <= c2_r + 1'b1;
          2'd3:    c3_r <= c3_r + 1'b1;
          default: c1_r <= c1_r;
        endcase
      end
    end
    p_r <= rd_idx;
    if (cmd.commit) begin
      status_r       <= status_w;
      slot_index_r   <= take ? 4'(best_r) : 4'd0;
      freed_count_r  <= (freed_w > 9'(FREED_MAX)) ? FREED_MAX : 5'(freed_w);
      avail_units_r  <= (units_w > 9'(UNITS_MAX)) ? UNITS_MAX : 6'(units_w);
      largest_free_r <= largest_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= '1;
      eval_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      eval_r <= cmd.rd_en;
      if (eval_r && rel_hit) begin
        free_r[p_r] <= 1'b1;
      end else if (cmd.commit && take) begin
        free_r[best_r] <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_busy         = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_slot_index   = slot_index_r;
  assign out_freed_count  = freed_count_r;
  assign out_avail_units  = avail_units_r;
  assign out_largest_free = largest_free_r;

endmodule

// File: hw/rtl/best_fit_partition_allocator.sv
// Best-fit fixed-partition allocator: top level joining sequencer and datapath.
// Result after a sweep of every partition through the owner memory read port, a drain of
// the read stage and a commit. A new item is accepted only once the last one has been
// committed and the sequencer is idle again; a result still held in the output register
// stalls the commit.
// Synchronous active-low reset frees every partition and empties the result register.
`timescale 1ns / 1ps
module best_fit_partition_allocator import bfpa_pkg::*; #(
  parameter int CLASS0_SLOTS = 4,
  parameter int CLASS1_SLOTS = 4,
  parameter int CLASS2_SLOTS = 8,
  parameter int TOTAL_SLOTS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bfpa_in_if.sink     in_ch,
  bfpa_out_if.source  out_ch
);

  localparam int IW = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

  cmd_t          cmd;
  logic [IW-1:0] rd_idx;
  logic          out_busy;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  bfpa_ctrl #(
    .TOTAL_SLOTS(TOTAL_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_busy (out_busy),
    .cmd      (cmd),
    .rd_idx   (rd_idx)
  );

  bfpa_dp #(
    .CLASS0_SLOTS(CLASS0_SLOTS),
    .CLASS1_SLOTS(CLASS1_SLOTS),
    .CLASS2_SLOTS(CLASS2_SLOTS),
    .TOTAL_SLOTS (TOTAL_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_idx           (rd_idx),
    .in_kind          (in_ch.kind),
    .in_owner_id      (in_ch.owner_id),
    .in_priority_req  (in_ch.priority_req),
    .out_busy         (out_busy),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_slot_index   (out_ch.slot_index),
    .out_freed_count  (out_ch.freed_count),
    .out_avail_units  (out_ch.avail_units),
    .out_largest_free (out_ch.largest_free)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the best-fit partition allocator: queued requests, predicted outcomes.
`timescale 1ns / 1ps
module tb_top;
  import bfpa_pkg::*;

  localparam int BIG_SLOTS   = 4;
  localparam int MID_SLOTS   = 4;
  localparam int SMALL_SLOTS = 8;
  localparam int SLOTS       = 16;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 3 * (SLOTS + 3);
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic        kind;
    logic [15:0] owner;
    logic [2:0]  prio;
    int unsigned phase;
  } request_t;

  typedef struct {
    status_t    status;
    logic [3:0] slot;
    logic [4:0] freed;
    logic [5:0] units;
    logic [1:0] largest;
  } outcome_t;

  logic clk;
  logic rst_n;

  bfpa_in_if  in_ch();
  bfpa_out_if out_ch();

  best_fit_partition_allocator #(
    .CLASS0_SLOTS(BIG_SLOTS),
    .CLASS1_SLOTS(MID_SLOTS),
    .CLASS2_SLOTS(SMALL_SLOTS),
    .TOTAL_SLOTS(SLOTS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  bit          part_free[SLOTS];
  logic [15:0] part_owner[SLOTS];
  logic [1:0]  part_class[SLOTS];
  logic [1:0]  part_size[SLOTS];

  request_t request_q[$];
  outcome_t pending_outcomes[$];
  request_t held_req;
  int unsigned cur_phase;
  int unsigned fault_count;
  int unsigned cycle_count;

  function automatic outcome_t partition_outcome(request_t r);
    outcome_t o;
    logic [1:0] want_cls;
    int need;
    bit found;
    int best;
    int best_waste;
    int count;
    int sum;
    int big;
    o.status  = ST_NO_FIT;
    o.slot    = '0;
    o.freed   = '0;
    found     = 1'b0;
    best      = 0;
    best_waste = 0;
    count     = 0;
    if (r.kind == KIND_ALLOC) begin
      if (r.prio < PRIO_MID) begin
        want_cls = CLS_BIG;
        need = 3;
      end else if (r.prio == PRIO_MID) begin
        want_cls = CLS_MID;
        need = 2;
      end else begin
        want_cls = CLS_SMALL;
        need = 1;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (part_free[i] && part_class[i] == want_cls && int'(part_size[i]) >= need) begin
          if (!found || int'(part_size[i]) - need < best_waste) begin
            found = 1'b1;
            best_waste = int'(part_size[i]) - need;
            best = i;
          end
        end
      end
      if (found) begin
        part_free[best]  = 1'b0;
        part_owner[best] = r.owner;
        o.status = ST_ALLOCATED;
        o.slot   = best[3:0];
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!part_free[i] && part_owner[i] == r.owner) begin
          part_free[i] = 1'b1;
          count++;
        end
      end
      o.status = (count != 0) ? ST_RELEASED : ST_NO_MATCH;
      o.freed  = (count > int'(FREED_MAX)) ? FREED_MAX : count[4:0];
    end
    sum = 0;
    big = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (part_free[i]) begin
        sum += int'(part_size[i]);
        if (int'(part_size[i]) > big) big = int'(part_size[i]);
      end
    end
    o.units   = (sum > int'(UNITS_MAX)) ? UNITS_MAX : sum[5:0];
    o.largest = big[1:0];
    return o;
  endfunction

  task automatic queue_request(logic kind, logic [15:0] owner, logic [2:0] prio,
                               int unsigned phase);
    request_t r;
    r.kind  = kind;
    r.owner = owner;
    r.prio  = prio;
    r.phase = phase;
    request_q.push_back(r);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_ALLOC;
    in_ch.owner_id     = '0;
    in_ch.priority_req = '0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      part_free[i]  = 1'b1;
      part_owner[i] = '0;
      if (i < BIG_SLOTS) begin
        part_class[i] = CLS_BIG;
        part_size[i]  = 2'd3;
      end else if (i < BIG_SLOTS + MID_SLOTS) begin
        part_class[i] = CLS_MID;
        part_size[i]  = 2'd2;
      end else if (i < BIG_SLOTS + MID_SLOTS + SMALL_SLOTS) begin
        part_class[i] = CLS_SMALL;
        part_size[i]  = 2'd1;
      end else begin
        part_class[i] = CLS_NONE;
        part_size[i]  = 2'd0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : drive
    request_t nxt;
    int unsigned idle_pct;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pending_outcomes.push_back(partition_outcome(held_req));
      end
      if (!in_ch.valid || in_ch.ready) begin
        idle_pct = (cur_phase == 0) ? 35 : (cur_phase == 1) ? 69 : 0;
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = request_q.pop_front();
          held_req = nxt;
          cur_phase <= nxt.phase;
          in_ch.valid        <= 1'b1;
          in_ch.kind         <= nxt.kind;
          in_ch.owner_id     <= nxt.owner;
          in_ch.priority_req <= nxt.prio;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    outcome_t want;
    int unsigned stall_pct;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result: status %0d slot %0d freed %0d units %0d largest %0d",
                     out_ch.status, out_ch.slot_index, out_ch.freed_count,
                     out_ch.avail_units, out_ch.largest_free);
        end else begin
          want = pending_outcomes.pop_front();
          if (out_ch.status !== want.status || out_ch.slot_index !== want.slot ||
              out_ch.freed_count !== want.freed || out_ch.avail_units !== want.units ||
              out_ch.largest_free !== want.largest) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"mismatch: exp status %0d slot %0d freed %0d units %0d largest %0d",
                        " / got status %0d slot %0d freed %0d units %0d largest %0d"},
                       want.status, want.slot, want.freed, want.units, want.largest,
                       out_ch.status, out_ch.slot_index, out_ch.freed_count,
                       out_ch.avail_units, out_ch.largest_free);
          end
        end
      end
      stall_pct = (cur_phase == 0) ? 69 : (cur_phase == 1) ? 35 : 0;
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    logic [15:0] owners[8];
    int unsigned phase;
    int unsigned pick;
    fault_count = 0;
    cycle_count = 0;
    cur_phase   = 0;
    // release on an empty table, then fill every class past capacity
    queue_request(KIND_RELEASE, 16'h0000, 3'd0, 0);
    queue_request(KIND_ALLOC, 16'h0000, 3'd0, 0);
    queue_request(KIND_ALLOC, 16'hFFFF, 3'd1, 0);
    queue_request(KIND_ALLOC, 16'h1234, 3'd2, 0);
    queue_request(KIND_ALLOC, 16'h1234, 3'd2, 0);
    queue_request(KIND_ALLOC, 16'hBEEF, 3'd0, 0);
    queue_request(KIND_ALLOC, 16'h1234, 3'd3, 0);
    queue_request(KIND_ALLOC, 16'hFFFF, 3'd3, 0);
    queue_request(KIND_ALLOC, 16'h8001, 3'd3, 0);
    queue_request(KIND_ALLOC, 16'h0000, 3'd3, 0);
    queue_request(KIND_ALLOC, 16'h1234, 3'd3, 0);
    queue_request(KIND_ALLOC, 16'h1234, 3'd4, 0);
    queue_request(KIND_ALLOC, 16'hBEEF, 3'd5, 0);
    queue_request(KIND_ALLOC, 16'h1234, 3'd6, 0);
    queue_request(KIND_ALLOC, 16'h0000, 3'd7, 0);
    queue_request(KIND_ALLOC, 16'hFFFF, 3'd4, 0);
    queue_request(KIND_ALLOC, 16'h8001, 3'd5, 0);
    queue_request(KIND_ALLOC, 16'h1234, 3'd6, 0);
    queue_request(KIND_ALLOC, 16'h7FFE, 3'd7, 0);
    queue_request(KIND_ALLOC, 16'h5555, 3'd7, 0);
    // release several, repeat one on its now-free slots as a miss, then release three more owners
    queue_request(KIND_RELEASE, 16'h1234, 3'd7, 0);
    queue_request(KIND_RELEASE, 16'h1234, 3'd0, 0);
    queue_request(KIND_RELEASE, 16'h5555, 3'd5, 0);
    queue_request(KIND_RELEASE, 16'hFFFF, 3'd2, 0);
    queue_request(KIND_RELEASE, 16'h0000, 3'd6, 0);

    owners[0] = 16'h0000;
    owners[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) owners[i] = 16'($urandom_range(65535));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      phase = (i * 3) / RANDOM_ITEMS;
      pick  = $urandom_range(99);
      if (pick < 85) begin
        queue_request(($urandom_range(99) < 58) ? KIND_ALLOC : KIND_RELEASE,
                      owners[3'($urandom_range(7))], 3'($urandom_range(7)), phase);
      end else begin
        queue_request(1'($urandom_range(1)), 16'($urandom_range(65535)),
                      3'($urandom_range(7)), phase);
      end
    end

    while (request_q.size() != 0 || in_ch.valid === 1'b1 || pending_outcomes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_count == 0 && pending_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
